// File: rtl/ers_pkg.sv
package ers_pkg;

    localparam int POS_BITS  = 12;
    localparam int DIM_BITS  = 13;
    localparam int DIR_BITS  = 2;
    localparam int SLOT_BITS = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd480;

    typedef logic signed [1:0] step_t;

    localparam step_t STEP_NEG  = 2'sb11;
    localparam step_t STEP_ZERO = 2'sb00;
    localparam step_t STEP_POS  = 2'sb01;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

    typedef enum logic [DIR_BITS-1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        ST_STARTED = 2'd0,
        ST_MOVED   = 2'd1,
        ST_ZERO    = 2'd2,
        ST_BORDER  = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_index_t;

endpackage

// File: rtl/edge_routing_step_core.sv
// channel   | handshake              | payload
// s_        | s_valid / s_ready      | opcode, start_x/y, start_dir, edge_horizontal, rows
// m_        | m_valid / m_ready      | pos_x, pos_y, status
// cfg_      | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// One transaction per cycle while the m_ side is not stalled; each passes from the input
// register to the result register, and m_valid rises as the result register loads. The
// routing decision is combinational compares on the 3x3 window against the held position
// and last move; that state updates as each transaction leaves the input register. aresetn
// (synchronous) clears position, move and both valids and loads width 640, height 480. A
// stalled m_ side holds the result and, once the input register is full, drops s_ready.
module edge_routing_step_core #(
    parameter int COORD_BITS = 12,
    parameter int GRAD_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ers_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [ers_pkg::DIM_BITS-1:0]          cfg_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_opcode,
    input  logic [ers_pkg::POS_BITS-1:0]          s_start_x,
    input  logic [ers_pkg::POS_BITS-1:0]          s_start_y,
    input  logic [ers_pkg::DIR_BITS-1:0]          s_start_dir,
    input  logic                                  s_edge_horizontal,
    input  logic [3*ers_pkg::SLOT_BITS-1:0]       s_row_above,
    input  logic [2*ers_pkg::SLOT_BITS-1:0]       s_row_middle,
    input  logic [3*ers_pkg::SLOT_BITS-1:0]       s_row_below,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ers_pkg::POS_BITS-1:0]          m_pos_x,
    output logic [ers_pkg::POS_BITS-1:0]          m_pos_y,
    output logic [1:0]                            m_status
);

    localparam int SB = ers_pkg::SLOT_BITS;
    localparam int XW = (COORD_BITS > ers_pkg::POS_BITS) ? COORD_BITS : ers_pkg::POS_BITS;
    localparam int CW = (COORD_BITS + 1 > ers_pkg::DIM_BITS) ? COORD_BITS + 1
                                                             : ers_pkg::DIM_BITS;

    typedef logic signed [GRAD_BITS-1:0] grad_t;

    function automatic grad_t slot(input logic [SB-1:0] s);
        return grad_t'(s[GRAD_BITS-1:0]);
    endfunction

    // configuration
    logic [ers_pkg::DIM_BITS-1:0] width_reg;
    logic [ers_pkg::DIM_BITS-1:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ers_pkg::WIDTH_RESET;
            height_reg <= ers_pkg::HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (ers_pkg::cfg_index_t'(cfg_index))
                ers_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                ers_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    logic                          in_valid_reg;
    logic                          op_reg;
    logic [ers_pkg::POS_BITS-1:0]  start_x_reg;
    logic [ers_pkg::POS_BITS-1:0]  start_y_reg;
    logic [ers_pkg::DIR_BITS-1:0]  start_dir_reg;
    logic                          horiz_reg;
    logic [3*SB-1:0]               above_reg;
    logic [2*SB-1:0]               middle_reg;
    logic [3*SB-1:0]               below_reg;

    logic m_valid_reg;
    logic advance;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg        <= s_opcode;
            start_x_reg   <= s_start_x;
            start_y_reg   <= s_start_y;
            start_dir_reg <= s_start_dir;
            horiz_reg     <= s_edge_horizontal;
            above_reg     <= s_row_above;
            middle_reg    <= s_row_middle;
            below_reg     <= s_row_below;
        end
    end

    // walker state
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    ers_pkg::step_t        move_dx_reg, move_dx_next;
    ers_pkg::step_t        move_dy_reg, move_dy_next;
    ers_pkg::status_t      status_next;

    grad_t g_ul, g_u, g_ur, g_l, g_r, g_dl, g_d, g_dr;

    assign g_ul = slot(above_reg[0*SB +: SB]);
    assign g_u  = slot(above_reg[1*SB +: SB]);
    assign g_ur = slot(above_reg[2*SB +: SB]);
    assign g_l  = slot(middle_reg[0*SB +: SB]);
    assign g_r  = slot(middle_reg[1*SB +: SB]);
    assign g_dl = slot(below_reg[0*SB +: SB]);
    assign g_d  = slot(below_reg[1*SB +: SB]);
    assign g_dr = slot(below_reg[2*SB +: SB]);

    logic at_left, at_right, at_top, at_bottom;
    logic [CW-1:0] x_inc, y_inc;

    assign x_inc     = CW'(cur_x_reg) + CW'(1);
    assign y_inc     = CW'(cur_y_reg) + CW'(1);
    assign at_left   = (cur_x_reg == '0);
    assign at_top    = (cur_y_reg == '0);
    assign at_right  = (x_inc >= CW'(width_reg)) || (&cur_x_reg);
    assign at_bottom = (y_inc >= CW'(height_reg)) || (&cur_y_reg);

    logic [XW-1:0] start_x_ext, start_y_ext;

    assign start_x_ext = XW'(start_x_reg);
    assign start_y_ext = XW'(start_y_reg);

    ers_pkg::step_t sx, sy;
    logic           border;
    grad_t          c_top, c_mid, c_bot;
    grad_t          w_left, w_mid, w_right;
    grad_t          g_sel;

    always_comb begin
        // column on the side of a horizontal move, row on the side of a vertical move
        c_top = (move_dx_reg == ers_pkg::STEP_POS) ? g_ur : g_ul;
        c_mid = (move_dx_reg == ers_pkg::STEP_POS) ? g_r  : g_l;
        c_bot = (move_dx_reg == ers_pkg::STEP_POS) ? g_dr : g_dl;
        w_left  = (move_dy_reg == ers_pkg::STEP_POS) ? g_dl : g_ul;
        w_mid   = (move_dy_reg == ers_pkg::STEP_POS) ? g_d  : g_u;
        w_right = (move_dy_reg == ers_pkg::STEP_POS) ? g_dr : g_ur;

        sx     = ers_pkg::STEP_ZERO;
        sy     = ers_pkg::STEP_ZERO;
        border = 1'b0;

        if (horiz_reg) begin
            if (move_dx_reg != ers_pkg::STEP_ZERO) begin
                sx     = move_dx_reg;
                border = ((move_dx_reg == ers_pkg::STEP_POS) ? at_right : at_left)
                         || at_top || at_bottom;
                if (c_top > c_mid && c_top > c_bot) begin
                    sy = ers_pkg::STEP_NEG;
                end else if (c_bot > c_mid && c_bot > c_top) begin
                    sy = ers_pkg::STEP_POS;
                end
            end else begin
                sy     = (move_dy_reg == ers_pkg::STEP_POS) ? ers_pkg::STEP_POS
                                                            : ers_pkg::STEP_NEG;
                border = ((move_dy_reg == ers_pkg::STEP_POS) ? at_bottom : at_top)
                         || at_left || at_right;
                sx     = (w_left > w_right) ? ers_pkg::STEP_NEG : ers_pkg::STEP_POS;
            end
        end else begin
            if (move_dy_reg != ers_pkg::STEP_ZERO) begin
                sy     = move_dy_reg;
                border = ((move_dy_reg == ers_pkg::STEP_POS) ? at_bottom : at_top)
                         || at_left || at_right;
                if (w_right > w_mid && w_right > w_left) begin
                    sx = ers_pkg::STEP_POS;
                end else if (w_left > w_mid && w_left > w_right) begin
                    sx = ers_pkg::STEP_NEG;
                end
            end else begin
                sx     = (move_dx_reg == ers_pkg::STEP_POS) ? ers_pkg::STEP_POS
                                                            : ers_pkg::STEP_NEG;
                border = ((move_dx_reg == ers_pkg::STEP_POS) ? at_right : at_left)
                         || at_top || at_bottom;
                sy     = (c_top > c_bot) ? ers_pkg::STEP_NEG : ers_pkg::STEP_POS;
            end
        end

        if (sy == ers_pkg::STEP_NEG) begin
            g_sel = (sx == ers_pkg::STEP_NEG) ? g_ul :
                    (sx == ers_pkg::STEP_POS) ? g_ur : g_u;
        end else if (sy == ers_pkg::STEP_POS) begin
            g_sel = (sx == ers_pkg::STEP_NEG) ? g_dl :
                    (sx == ers_pkg::STEP_POS) ? g_dr : g_d;
        end else begin
            g_sel = (sx == ers_pkg::STEP_NEG) ? g_l  :
                    (sx == ers_pkg::STEP_POS) ? g_r  : '0;
        end
    end

    always_comb begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        move_dx_next = move_dx_reg;
        move_dy_next = move_dy_reg;
        status_next  = ers_pkg::ST_STARTED;

        case (ers_pkg::opcode_t'(op_reg))
            ers_pkg::OP_START: begin
                cur_x_next = start_x_ext[COORD_BITS-1:0];
                cur_y_next = start_y_ext[COORD_BITS-1:0];
                case (ers_pkg::dir_t'(start_dir_reg))
                    ers_pkg::DIR_UP: begin
                        move_dx_next = ers_pkg::STEP_ZERO;
                        move_dy_next = ers_pkg::STEP_NEG;
                    end
                    ers_pkg::DIR_DOWN: begin
                        move_dx_next = ers_pkg::STEP_ZERO;
                        move_dy_next = ers_pkg::STEP_POS;
                    end
                    ers_pkg::DIR_LEFT: begin
                        move_dx_next = ers_pkg::STEP_NEG;
                        move_dy_next = ers_pkg::STEP_ZERO;
                    end
                    default: begin
                        move_dx_next = ers_pkg::STEP_POS;
                        move_dy_next = ers_pkg::STEP_ZERO;
                    end
                endcase
                status_next = ers_pkg::ST_STARTED;
            end
            default: begin
                if (border) begin
                    move_dx_next = ers_pkg::STEP_ZERO;
                    move_dy_next = ers_pkg::STEP_ZERO;
                    status_next  = ers_pkg::ST_BORDER;
                end else begin
                    cur_x_next   = cur_x_reg + COORD_BITS'(sx);
                    cur_y_next   = cur_y_reg + COORD_BITS'(sy);
                    move_dx_next = sx;
                    move_dy_next = sy;
                    status_next  = (g_sel != '0) ? ers_pkg::ST_MOVED : ers_pkg::ST_ZERO;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            move_dx_reg <= ers_pkg::STEP_ZERO;
            move_dy_reg <= ers_pkg::STEP_ZERO;
        end else if (advance) begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            move_dx_reg <= move_dx_next;
            move_dy_reg <= move_dy_next;
        end
    end

    // result register
    logic [XW-1:0]                pos_x_ext, pos_y_ext;
    logic [ers_pkg::POS_BITS-1:0] pos_x_reg, pos_y_reg;
    ers_pkg::status_t             status_reg;

    assign pos_x_ext = XW'(cur_x_next);
    assign pos_y_ext = XW'(cur_y_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pos_x_reg  <= pos_x_ext[ers_pkg::POS_BITS-1:0];
            pos_y_reg  <= pos_y_ext[ers_pkg::POS_BITS-1:0];
            status_reg <= status_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_pos_x  = pos_x_reg;
    assign m_pos_y  = pos_y_reg;
    assign m_status = status_reg;

    a_border_clears_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && status_next == ers_pkg::ST_BORDER)
        |=> (move_dx_reg == ers_pkg::STEP_ZERO && move_dy_reg == ers_pkg::STEP_ZERO))
        else $error("border stop left a move behind");

    a_border_holds_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && status_next == ers_pkg::ST_BORDER)
        |=> (cur_x_reg == $past(cur_x_reg) && cur_y_reg == $past(cur_y_reg)))
        else $error("border stop moved the position");

    a_step_has_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && status_next != ers_pkg::ST_BORDER)
        |=> (move_dx_reg != ers_pkg::STEP_ZERO || move_dy_reg != ers_pkg::STEP_ZERO))
        else $error("transaction left no move");

    a_move_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (move_dx_reg != 2'sb10 && move_dy_reg != 2'sb10))
        else $error("move out of range");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance)
        |=> (in_valid_reg && $stable(op_reg) && $stable(horiz_reg)))
        else $error("stalled transaction lost");

endmodule
